@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lis_pkg.sv @@
package lis_pkg;

    localparam int MAX_ELEMENTS_DEFAULT = 64;
    localparam int VALUE_W              = 32;
    localparam int CHAIN_LEN_W          = 7;
    localparam int POSITION_W           = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } lis_in_t;

    typedef struct packed {
        logic [CHAIN_LEN_W-1:0] chain_length;
        logic [POSITION_W-1:0]  position;
        logic                   last_of_run;
    } lis_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic row_read;
        logic row_init;
        logic scan;
        logic pick_mode;
        logic write_row;
        logic pick_init;
        logic emit_init;
        logic emit;
        logic follow;
    } lis_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_fire;
        logic scan_done;
        logic row_zero;
        logic out_free;
        logic emit_last;
    } lis_status_t;

endpackage

@@ rtl/lis_stream_if.sv @@
interface lis_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lis_ram.sv @@
module lis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lis_ctrl.sv @@
module lis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lis_pkg::lis_status_t status,
    output lis_pkg::lis_cmd_t    cmd
);
    import lis_pkg::*;

    typedef enum logic [7:0] {
        S_LOAD      = 8'b0000_0001,
        S_ROW       = 8'b0000_0010,
        S_ROW_WAIT  = 8'b0000_0100,
        S_SCAN      = 8'b0000_1000,
        S_PICK_INIT = 8'b0001_0000,
        S_PICK      = 8'b0010_0000,
        S_EMIT      = 8'b0100_0000,
        S_NEXT      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.last_fire)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row_read = 1'b1;
                state_next   = S_ROW_WAIT;
            end
            S_ROW_WAIT:
            begin
                cmd.row_init = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.write_row = 1'b1;
                    state_next    = status.row_zero ? S_PICK_INIT : S_ROW;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_PICK_INIT:
            begin
                cmd.pick_init = 1'b1;
                state_next    = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick_mode = 1'b1;
                if (status.scan_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.emit_last ? S_LOAD : S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.follow = 1'b1;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end
endmodule

@@ rtl/lis_dp.sv @@
module lis_dp #(
    parameter int MAX_ELEMENTS = lis_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lis_pkg::lis_cmd_t    cmd,
    output lis_pkg::lis_status_t status,
    lis_stream_if.sink           items,
    lis_stream_if.source         results
);
    import lis_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

    // control registers
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             out_valid_reg, out_valid_next;

    // working registers
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic signed [VALUE_W-1:0] vi_reg, vi_next;
    logic [CNT_W-1:0]          best_reg, best_next;
    logic [IDX_W-1:0]          succ_reg, succ_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    lis_out_t                  out_reg, out_next;

    // memory ports
    logic                   val_we;
    logic [IDX_W-1:0]       val_raddr;
    logic [VALUE_W-1:0]     val_rdata;
    logic [CNT_W-1:0]       len_rdata;
    logic [IDX_W-1:0]       nxt_rdata;

    logic                   in_fire;
    logic                   store_ok;
    logic [CNT_W-1:0]       count_after;
    logic                   more_to_scan;
    logic [CNT_W+CHAIN_LEN_W-1:0] len_wide;
    logic [IDX_W+POSITION_W-1:0]  pos_wide;

    assign in_fire      = items.valid && items.ready;
    assign store_ok     = count_reg < MAX_CNT;
    assign count_after  = store_ok ? count_reg + ONE_CNT : count_reg;
    assign more_to_scan = j_reg < count_reg;
    assign val_we       = in_fire && store_ok;
    assign val_raddr    = cmd.row_read ? i_reg : j_reg[IDX_W-1:0];
    assign len_wide     = {{CHAIN_LEN_W{1'b0}}, best_reg};
    assign pos_wide     = {{POSITION_W{1'b0}}, pos_reg};

    assign items.ready   = cmd.load;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    assign status.last_fire = in_fire && items.data.last_value;
    assign status.scan_done = !more_to_scan && !cmp_valid_reg;
    assign status.row_zero  = i_reg == '0;
    assign status.out_free  = !out_valid_reg || results.ready;
    assign status.emit_last = remain_reg == ONE_CNT;

    lis_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (items.data.value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    lis_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ELEMENTS)) u_len_ram (
        .clk   (clk),
        .we    (cmd.write_row),
        .waddr (i_reg),
        .wdata (best_reg),
        .raddr (j_reg[IDX_W-1:0]),
        .rdata (len_rdata)
    );

    lis_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_next_ram (
        .clk   (clk),
        .we    (cmd.write_row),
        .waddr (i_reg),
        .wdata (succ_reg),
        .raddr (pos_reg),
        .rdata (nxt_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        cmp_valid_next = cmp_valid_reg;
        out_valid_next = out_valid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmp_idx_next   = cmp_idx_reg;
        vi_next        = vi_reg;
        best_next      = best_reg;
        succ_next      = succ_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        out_next       = out_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            count_next = count_after;
            if (items.data.last_value)
            begin
                i_next = IDX_W'(count_after - ONE_CNT);
            end
        end

        if (cmd.row_init)
        begin
            vi_next        = $signed(val_rdata);
            best_next      = ONE_CNT;
            succ_next      = '0;
            j_next         = CNT_W'({1'b0, i_reg}) + ONE_CNT;
            cmp_valid_next = 1'b0;
        end

        if (cmd.pick_init)
        begin
            best_next      = '0;
            succ_next      = '0;
            j_next         = '0;
            cmp_valid_next = 1'b0;
        end

        if (cmd.scan)
        begin
            // issue the next candidate read
            cmp_valid_next = more_to_scan;
            if (more_to_scan)
            begin
                cmp_idx_next = j_reg[IDX_W-1:0];
                j_next       = j_reg + ONE_CNT;
            end
            // judge the candidate read last cycle
            if (cmp_valid_reg)
            begin
                if (cmd.pick_mode)
                begin
                    if (len_rdata > best_reg)
                    begin
                        best_next = len_rdata;
                        succ_next = cmp_idx_reg;
                    end
                end
                else if ((vi_reg < $signed(val_rdata)) && (len_rdata >= best_reg))
                begin
                    best_next = len_rdata + ONE_CNT;
                    succ_next = cmp_idx_reg;
                end
            end
        end

        if (cmd.write_row)
        begin
            i_next = i_reg - ONE_IDX;
        end

        if (cmd.emit_init)
        begin
            pos_next    = succ_reg;
            remain_next = best_reg;
        end

        if (cmd.emit)
        begin
            out_valid_next        = 1'b1;
            out_next.chain_length = len_wide[CHAIN_LEN_W-1:0];
            out_next.position     = pos_wide[POSITION_W-1:0];
            out_next.last_of_run  = remain_reg == ONE_CNT;
            remain_next           = remain_reg - ONE_CNT;
            if (remain_reg == ONE_CNT)
            begin
                count_next = '0;
            end
        end

        if (cmd.follow)
        begin
            pos_next = nxt_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        cmp_idx_reg <= cmp_idx_next;
        vi_reg      <= vi_next;
        best_reg    <= best_next;
        succ_reg    <= succ_next;
        pos_reg     <= pos_next;
        remain_reg  <= remain_next;
        out_reg     <= out_next;
    end
endmodule

@@ rtl/longest_increasing_subsequence.sv @@
// Longest strictly increasing subsequence finder. Signed 32-bit values are
// loaded one per input item, the item with last_value set ends the sequence
// (items past MAX_ELEMENTS are dropped, but a dropped last item still ends it).
// Input is ready throughout loading. After the last item the block solves the
// backward dynamic program, one candidate comparison per cycle through the
// single read port of the value and length memories, then scans the stored
// lengths to pick the first position with the greatest length. The chain is
// then emitted one result item per element, with a successor memory read
// between items, each carrying the chain length and a last_of_run mark on the
// final element; emission stalls while the output register holds an untaken item.
// Input is not taken from the last item until the final result is loaded
// into the output register; that register lets the next sequence load
// while the final result still waits to be taken. On equal lengths the
// lowest index wins, and a sequence with no increasing pair emits index 0.
module longest_increasing_subsequence #(
    parameter int MAX_ELEMENTS = lis_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    lis_stream_if.sink   items,
    lis_stream_if.source results
);
    import lis_pkg::*;

    // command and status between sequencer and datapath
    lis_cmd_t    cmd;
    lis_status_t status;

    // sequencer: load, per-row scan, pick, chain walk
    lis_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: value, length and successor memories, compare unit,
    // output register
    lis_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .items   (items),
        .results (results)
    );
endmodule

@@ rtl/lis_checker.sv @@
`include "assert_macros.svh"

module lis_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input lis_pkg::lis_out_t out_data
);
    import lis_pkg::*;

    logic                   in_fire;
    logic                   out_fire;
    logic                   mid_run_reg, mid_run_next;
    logic [CHAIN_LEN_W-1:0] len_reg, len_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // remember the length of a run that is partly delivered
    always_comb
    begin
        mid_run_next = mid_run_reg;
        len_next     = len_reg;
        if (out_fire)
        begin
            mid_run_next = !out_data.last_of_run;
            len_next     = out_data.chain_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_run_reg <= 1'b0;
            len_reg     <= '0;
        end
        else
        begin
            mid_run_reg <= mid_run_next;
            len_reg     <= len_next;
        end
    end

    `LIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "result item dropped or changed while stalled")

    `LIS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_fire && in_last,
        !in_ready, "item taken right after the last item of a sequence")

    `LIS_ASSERT_NOW(a_run_len_same, clk, rst_n, out_valid && mid_run_reg,
        out_data.chain_length == len_reg, "chain length changed inside one run")
endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_last   (items.data.last_value),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lis_pkg::*;

    // block capacity and run shape
    localparam int CAPACITY    = 64;
    localparam int ITEM_TARGET = 350;
    // long receiver hold-off, counted in the receiver process
    localparam int HOLD_CYCLES = 400;
    // cycles with no handshake on either side before the run is abandoned
    localparam int STALL_LIMIT = 20000;
    // mismatches printed in full, the rest only counted
    localparam int REPORT_MAX  = 10;
    // cycles allowed after the last expected result for anything stray
    localparam int TAIL_CYCLES = 100;

    // how the values of one sequence are drawn
    typedef enum {VAL_FULL, VAL_NARROW, VAL_RISING, VAL_FALLING, VAL_STRICT} value_mode_t;
    // receiver stall patterns
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // predicts the emitted chain of each sequence and checks results in order
    class chain_scoreboard_t;
        logic signed [VALUE_W-1:0] seq_values[$];
        lis_out_t                  expected_chain[$];
        bit                        seq_dropped;
        int                        n_items;
        int                        n_sequences;
        int                        n_overflow;
        int                        n_results;
        int                        n_errors;
        int                        longest;

        // one accepted input item; the last one of a sequence yields the chain
        function void note_item(lis_in_t it);
            n_items++;
            if (seq_values.size() < CAPACITY)
                seq_values.insert(seq_values.size(), it.value);
            else
                seq_dropped = 1'b1;
            if (it.last_value)
            begin
                solve_chain();
                if (seq_dropped)
                    n_overflow++;
                seq_values.delete();
                seq_dropped = 1'b0;
                n_sequences++;
            end
        endfunction

        // backward quadratic pass, then walk from the first longest start
        function void solve_chain();
            int       cnt;
            int       best;
            int       start;
            int       pos;
            int       chain_len[CAPACITY];
            int       next_idx[CAPACITY];
            lis_out_t r;
            cnt = seq_values.size();
            for (int i = cnt - 1; i >= 0; i--)
            begin
                chain_len[i] = 1;
                next_idx[i]  = 0;
                // strict increase; only a strictly longer candidate replaces,
                // so the lowest index wins a tie
                for (int j = i + 1; j < cnt; j++)
                begin
                    if (seq_values[i] < seq_values[j] && chain_len[i] < chain_len[j] + 1)
                    begin
                        chain_len[i] = chain_len[j] + 1;
                        next_idx[i]  = j;
                    end
                end
            end
            start = 0;
            best  = chain_len[0];
            for (int k = 1; k < cnt; k++)
            begin
                if (chain_len[k] > best)
                begin
                    best  = chain_len[k];
                    start = k;
                end
            end
            pos = start;
            for (int k = 0; k < best; k++)
            begin
                r.chain_length = CHAIN_LEN_W'(best);
                r.position     = POSITION_W'(pos);
                r.last_of_run  = (k == best - 1);
                expected_chain.insert(expected_chain.size(), r);
                pos = next_idx[pos];
            end
            if (best > longest)
                longest = best;
        endfunction

        // one accepted result against the oldest expectation
        function void check_result(lis_out_t got);
            lis_out_t want;
            n_results++;
            if (expected_chain.size() == 0)
            begin
                n_errors++;
                if (n_errors <= REPORT_MAX)
                    $display("unexpected result: length %0d position %0d last %0b",
                             got.chain_length, got.position, got.last_of_run);
                return;
            end
            want = expected_chain.pop_front();
            if (got.chain_length !== want.chain_length || got.position !== want.position ||
                got.last_of_run !== want.last_of_run)
            begin
                n_errors++;
                if (n_errors <= REPORT_MAX)
                    $display({"result %0d: expected len %0d pos %0d last %0b,",
                              " got len %0d pos %0d last %0b"},
                             n_results, want.chain_length, want.position, want.last_of_run,
                             got.chain_length, got.position, got.last_of_run);
            end
        endfunction

        function int pending();
            return expected_chain.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lis_stream_if #(.payload_t(lis_in_t))  item_if ();
    lis_stream_if #(.payload_t(lis_out_t)) result_if ();

    longest_increasing_subsequence #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .items(item_if),
        .results(result_if)
    );

    chain_scoreboard_t board = new();

    // sender state
    int n_sent;
    int burst_left;
    bit tx_idle;
    int n_drains;
    // set by the sender, served and cleared by the receiver
    bit hold_request;
    int n_holds;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitor: results are checked before a same-edge input is noted,
    // since a result can never belong to a sequence that ends on that edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
                board.check_result(result_if.data);
            if (item_if.valid && item_if.ready)
                board.note_item(item_if.data);
        end
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: stall patterns of random length, plus the long hold-off
    initial
    begin
        rx_mode_t mode;
        int       left;
        int       tick;
        result_if.ready = 1'b0;
        mode = RX_OPEN;
        left = 0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                // block fills up behind this and stalls its input
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_request = 1'b0;
                n_holds++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(8, 64);
                end
                left--;
                tick++;
                case (mode)
                    RX_OPEN:     result_if.ready <= 1'b1;
                    RX_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   result_if.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: result_if.ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // offer one item and hold it until taken; bursts end in a random gap when tx_idle is set
    task automatic send_item(logic signed [VALUE_W-1:0] v, logic is_last);
        lis_in_t it;
        int      gap;
        it.value      = v;
        it.last_value = is_last;
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do
            @(posedge clk);
        while (!item_if.ready);
        n_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = tx_idle ? $urandom_range(1, 7) : 0;
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_list(int vals[$]);
        for (int k = 0; k < vals.size(); k++)
            send_item(vals[k], k == vals.size() - 1);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(value_mode_t m, int k);
        case (m)
            VAL_FULL:    return $urandom;
            VAL_NARROW:  return int'($urandom_range(0, 16)) - 8;
            // overlapping steps give chains with gaps and repeats
            VAL_RISING:  return k * 3 + int'($urandom_range(0, 5)) - 20;
            VAL_FALLING: return 500 - k * 3 + int'($urandom_range(0, 5));
            default:     return k * 4 + int'($urandom_range(0, 3)) - 100;
        endcase
    endfunction

    task automatic send_sequence(int len, value_mode_t m);
        for (int k = 0; k < len; k++)
            send_item(pick_value(m, k), k == len - 1);
    endtask

    // sender pause until every predicted result has been taken; it waits for
    // a clock edge first so the monitor has noted the item taken on the current edge
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        n_drains++;
    endtask

    initial
    begin
        int          dq[$];
        int          seq_no;
        value_mode_t vm;
        rst_n         = 1'b0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        n_sent        = 0;
        burst_left    = 1;
        tx_idle       = 1'b0;
        hold_request  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element
        dq = '{0};
        send_list(dq);
        // no increasing pair: index 0 alone
        dq = '{5, 3, 1};
        send_list(dq);
        // equal values do not chain
        dq = '{7, 7, 7};
        send_list(dq);
        // value extremes, both orders
        dq = '{-2147483647 - 1, 2147483647};
        send_list(dq);
        dq = '{2147483647, -2147483647 - 1};
        send_list(dq);
        // equal-length successors: lower index taken
        dq = '{1, 5, 4};
        send_list(dq);
        // longest chain starts past position 0
        dq = '{3, 1, 2, 0, -1, 4};
        send_list(dq);
        dq = '{-1, 0, 1};
        send_list(dq);
        drain();

        // random sequences, mostly short, with one full and one oversized
        tx_idle = 1'b1;
        seq_no  = 0;
        while (n_sent < ITEM_TARGET)
        begin
            seq_no++;
            if (seq_no % 8 == 0)
                tx_idle = !tx_idle;
            if (seq_no == 4)
            begin
                // strictly rising: longest possible chain, full capacity
                send_sequence(CAPACITY, VAL_STRICT);
            end
            else if (seq_no == 10)
            begin
                // receiver holds off while several sequences are offered
                hold_request = 1'b1;
                tx_idle      = 1'b0;
                repeat (6) send_sequence($urandom_range(2, 8), VAL_NARROW);
            end
            else if (seq_no == 14)
            begin
                // items past capacity dropped, dropped last still ends it
                vm = value_mode_t'($urandom_range(0, 4));
                send_sequence(CAPACITY + $urandom_range(1, 6), vm);
            end
            else
            begin
                vm = value_mode_t'($urandom_range(0, 4));
                send_sequence($urandom_range(1, 12), vm);
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d sequences (%0d over capacity) from %0d items,",
                 board.n_sequences, board.n_overflow, board.n_items);
        $display("%0d results, longest chain %0d, receiver hold-offs %0d, sender drains %0d",
                 board.n_results, board.longest, n_holds, n_drains);
        if (board.n_errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("mismatches %0d, left over %0d", board.n_errors, board.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
